// ===== src/lis_pkg.sv =====
// Package with the beat types, request kinds and control structs of the LCD serializer.
package lis_pkg;

  localparam logic [2:0] KIND_INIT   = 3'd0;
  localparam logic [2:0] KIND_CMD    = 3'd1;
  localparam logic [2:0] KIND_CHAR   = 3'd2;
  localparam logic [2:0] KIND_CLEAR  = 3'd3;
  localparam logic [2:0] KIND_CURSOR = 3'd4;
  localparam logic [2:0] KIND_INT    = 3'd5;

  // Last phase of a unit: a wait-only beat, a single nibble, or a full byte.
  localparam logic [1:0] LAST_PH_WAIT = 2'd0;
  localparam logic [1:0] LAST_PH_NIB  = 2'd1;
  localparam logic [1:0] LAST_PH_BYTE = 2'd3;

  localparam int unsigned        NUM_DIGITS     = 10;
  localparam logic [3:0]         INIT_LAST_UNIT = 4'd9;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [1:0]  row;
    logic [5:0]  col;
  } lis_in_t;

  typedef struct packed {
    logic       send;
    logic [7:0] expander_byte;
    logic [5:0] wait_ms;
    logic       last;
  } lis_out_t;

  typedef struct packed {
    logic       load;
    logic       conv;
    logic       shift;
    logic       emit;
    logic       last;
    logic [3:0] unit;
    logic [1:0] phase;
  } lis_cmd_t;

  typedef struct packed {
    logic       is_init;
    logic       is_int;
    logic       top_zero;
    logic       out_free;
    logic [1:0] last_phase;
  } lis_stat_t;

endpackage

// ===== src/lis_ctrl.sv =====
// Controller state machine that sequences conversion, digit skipping and beat emission.
module lis_ctrl
  import lis_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_kind,
  output logic       in_ready,
  input  lis_stat_t  stat,
  output lis_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SKIP = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [4:0] bit_r, bit_nxt;
  logic [3:0] rem_r, rem_nxt;
  logic [3:0] unit_r, unit_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       last_unit;

  always_comb begin
    if (stat.is_init) begin
      last_unit = (unit_r == INIT_LAST_UNIT);
    end else if (stat.is_int) begin
      last_unit = (rem_r == 4'd1);
    end else begin
      last_unit = 1'b1;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    bit_nxt   = bit_r;
    rem_nxt   = rem_r;
    unit_nxt  = unit_r;
    phase_nxt = phase_r;
    cmd       = '0;
    cmd.unit  = unit_r;
    cmd.phase = phase_r;
    cmd.last  = last_unit && (phase_r == stat.last_phase);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          unit_nxt  = 4'd0;
          phase_nxt = 2'd0;
          bit_nxt   = 5'd0;
          if (in_kind == KIND_INT) begin
            state_nxt = S_CONV;
          end else if (in_kind < KIND_INT) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_CONV: begin
        cmd.conv = 1'b1;
        bit_nxt  = bit_r + 5'd1;
        if (bit_r == 5'd31) begin
          state_nxt = S_SKIP;
          rem_nxt   = 4'(NUM_DIGITS);
        end
      end
      S_SKIP: begin
        // Drop leading zero digits but always keep the units digit.
        if (stat.top_zero && (rem_r > 4'd1)) begin
          cmd.shift = 1'b1;
          rem_nxt   = rem_r - 4'd1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (phase_r == stat.last_phase) begin
            phase_nxt = 2'd0;
            if (last_unit) begin
              state_nxt = S_IDLE;
            end else begin
              unit_nxt = unit_r + 4'd1;
              if (stat.is_int) begin
                cmd.shift = 1'b1;
                rem_nxt   = rem_r - 4'd1;
              end
            end
          end else begin
            phase_nxt = phase_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bit_r   <= 5'd0;
      rem_r   <= 4'd0;
      unit_r  <= 4'd0;
      phase_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
      rem_r   <= rem_nxt;
      unit_r  <= unit_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== src/lis_dpath.sv =====
// Datapath: request registers, binary to BCD converter, beat formatting and output register.
module lis_dpath
  import lis_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  lis_in_t   in_data,
  input  lis_cmd_t  cmd,
  output lis_stat_t stat,
  output logic      out_valid,
  input  logic      out_ready,
  output lis_out_t  out_data
);

  localparam int unsigned BCD_W = 4 * NUM_DIGITS;

  logic [2:0]       kind_r;
  logic [7:0]       byte_r;
  logic [1:0]       row_r;
  logic [5:0]       col_r;
  logic [31:0]      bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt, bcd_adj;
  logic             out_valid_r, out_valid_nxt;
  lis_out_t         out_data_r;

  logic [7:0] unit_byte;
  logic       unit_rs;
  logic [5:0] unit_extra;
  logic [1:0] last_phase;
  logic [7:0] row_base;
  logic [3:0] nibble;
  lis_out_t   beat;

  // One double-dabble step: correct every digit, then shift in the next bit.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                    : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (cmd.load) begin
      bin_nxt = in_data.value;
      bcd_nxt = '0;
    end else if (cmd.conv) begin
      bin_nxt = {bin_r[30:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[31]};
    end else if (cmd.shift) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
    end
  end

  always_comb begin
    case (row_r)
      2'd0:    row_base = 8'h00;
      2'd1:    row_base = 8'h40;
      2'd2:    row_base = 8'h10;
      default: row_base = 8'h50;
    endcase
  end

  // Describe the current unit: data byte, RS, extra wait after its last beat.
  always_comb begin
    unit_byte  = 8'h00;
    unit_rs    = 1'b0;
    unit_extra = 6'd2;
    last_phase = LAST_PH_BYTE;
    case (kind_r)
      KIND_INIT: begin
        case (cmd.unit)
          4'd0: begin
            last_phase = LAST_PH_WAIT;
          end
          4'd1: begin
            unit_byte  = 8'h30;
            unit_extra = 6'd5;
            last_phase = LAST_PH_NIB;
          end
          4'd2, 4'd3: begin
            unit_byte  = 8'h30;
            unit_extra = 6'd1;
            last_phase = LAST_PH_NIB;
          end
          4'd4: begin
            unit_byte  = 8'h20;
            unit_extra = 6'd1;
            last_phase = LAST_PH_NIB;
          end
          4'd5: unit_byte = 8'h28;
          4'd6: unit_byte = 8'h08;
          4'd7: begin
            unit_byte  = 8'h01;
            unit_extra = 6'd7;
          end
          4'd8:    unit_byte = 8'h06;
          default: unit_byte = 8'h0C;
        endcase
      end
      KIND_CMD: unit_byte = byte_r;
      KIND_CHAR: begin
        unit_byte  = byte_r;
        unit_rs    = 1'b1;
        unit_extra = 6'd1;
      end
      KIND_CLEAR: begin
        unit_byte  = 8'h01;
        unit_extra = 6'd7;
      end
      KIND_CURSOR: unit_byte = (row_base + {2'b00, col_r}) | 8'h80;
      default: begin
        unit_byte  = {4'h3, bcd_r[BCD_W-1 -: 4]};
        unit_rs    = 1'b1;
        unit_extra = 6'd1;
      end
    endcase
  end

  always_comb begin
    nibble = cmd.phase[1] ? unit_byte[3:0] : unit_byte[7:4];
    beat.last = cmd.last;
    if (last_phase == LAST_PH_WAIT) begin
      beat.send          = 1'b0;
      beat.expander_byte = 8'h00;
      beat.wait_ms       = 6'd50;
    end else begin
      beat.send          = 1'b1;
      beat.expander_byte = {nibble, 1'b1, ~cmd.phase[0], 1'b0, unit_rs};
      beat.wait_ms       = (cmd.phase == last_phase) ? 6'd1 + unit_extra : 6'd1;
    end
  end

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    if (cmd.load) begin
      kind_r <= in_data.kind;
      byte_r <= in_data.value[7:0];
      row_r  <= in_data.row;
      col_r  <= in_data.col;
    end
    if (cmd.emit) begin
      out_data_r <= beat;
    end
  end

  assign stat.is_init    = (kind_r == KIND_INIT);
  assign stat.is_int     = (kind_r == KIND_INT);
  assign stat.top_zero   = (bcd_r[BCD_W-1 -: 4] == 4'd0);
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.last_phase = last_phase;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/lcd_i2c_request_serializer.sv =====
// Top level of the HD44780 4-bit over I2C expander request serializer.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_ready   | lis_in_t  (kind, value, row, col)
//   out_    | output    | out_valid/out_ready | lis_out_t (send, expander_byte, wait_ms, last)
//
// Requests are taken only when idle. Beats leave one per cycle while out_ready takes them;
// in_ready stays low from the accept until the last beat of the request is emitted. An integer
// first runs the BCD conversion over all 32 bits, then drops leading zero digits but keeps the units digit.
// Unknown kinds give no beat; the longest request is an integer of ten digits.
// Reset is synchronous and active low; it clears the controller and the output valid flag.
// While a registered beat waits for out_ready, the sequence freezes.
module lcd_i2c_request_serializer
  import lis_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lis_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output lis_out_t out_data
);

  lis_cmd_t  cmd;
  lis_stat_t stat;

  lis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lis_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
